// ----- rtl/shader_bytecode_token_decoder_defines.svh -----
// Assertion macros used by the checker file sbtd_checker.sv.
`ifndef SHADER_BYTECODE_TOKEN_DECODER_DEFINES_SVH
`define SHADER_BYTECODE_TOKEN_DECODER_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SBTD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBTD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sbtd_pkg.sv -----
package sbtd_pkg;

  localparam int unsigned OPCODE_TABLE_DEPTH = 98;
  localparam int unsigned OP_ROM_IDX_W       = $clog2(OPCODE_TABLE_DEPTH);

  localparam logic [15:0] SHADER_TYPE_PS = 16'hffff;
  localparam logic [7:0]  MIN_MAJOR      = 8'd2;
  localparam logic [15:0] OP_DCL         = 16'd31;
  localparam logic [15:0] OP_DEF         = 16'd81;
  localparam logic [15:0] OP_COMMENT     = 16'hfffe;
  localparam logic [15:0] OP_END         = 16'hffff;

  typedef enum logic [3:0] {
    KIND_VERSION_OK   = 4'd0,
    KIND_REJECTED     = 4'd1,
    KIND_OPCODE       = 4'd2,
    KIND_COMMENT_HEAD = 4'd3,
    KIND_COMMENT_BODY = 4'd4,
    KIND_DST          = 4'd5,
    KIND_SRC          = 4'd6,
    KIND_DEF_VALUE    = 4'd7,
    KIND_DCL_USAGE    = 4'd8,
    KIND_EXTRA        = 4'd9,
    KIND_END          = 4'd10,
    KIND_IGNORED      = 4'd11
  } kind_e;

  typedef enum logic [1:0] {
    PH_HALTED,
    PH_OPCODE,
    PH_INSTR,
    PH_COMMENT
  } phase_e;

  typedef enum logic [1:0] {
    CLS_GENERIC = 2'd0,
    CLS_DEF     = 2'd1,
    CLS_DCL     = 2'd2
  } class_e;

  typedef struct packed {
    logic [31:0] token;
    logic        program_start;
  } in_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] type_code;
    logic [7:0]  major_or_dst_count;
    logic [7:0]  minor_or_src_count;
    logic [15:0] length_count;
    logic [10:0] reg_number;
    logic [4:0]  reg_type;
    logic [7:0]  mask_or_swizzle;
    logic [2:0]  modifier;
    logic [3:0]  usage;
    logic [3:0]  usage_index;
    logic [31:0] raw_word;
  } out_word_t;

  typedef struct packed {
    logic       dst;
    logic [1:0] src;
  } op_info_t;

  // parameter counts per opcode; types past the table use its last entry
  function automatic op_info_t op_rom_lookup(input logic [15:0] op_type);
    logic [OP_ROM_IDX_W-1:0] idx;
    op_info_t                info;
    if (op_type < 16'(OPCODE_TABLE_DEPTH)) begin
      idx = op_type[OP_ROM_IDX_W-1:0];
    end else begin
      idx = OP_ROM_IDX_W'(OPCODE_TABLE_DEPTH - 1);
    end
    unique case (idx) inside
      1, 6, 7, 14, 15, 16, 19, 35, 36: begin
        info = '{dst: 1'b1, src: 2'd1};
      end
      2, 3, 5, 8, 9, 10, 11, 12, 13, 17, 32, 66: begin
        info = '{dst: 1'b1, src: 2'd2};
      end
      4, 18, 37, 80, 88, 90: begin
        info = '{dst: 1'b1, src: 2'd3};
      end
      default: begin
        info = '{dst: 1'b0, src: 2'd0};
      end
    endcase
    return info;
  endfunction

endpackage

// ----- rtl/shader_bytecode_token_decoder.sv -----
// Pixel shader bytecode token decoder.
// Input channel (in_valid_i / in_ready_o / in_data_i): one 32-bit bytecode
// token per word, with program_start set on the version token of a program.
// Output channel (out_valid_o / out_ready_i / out_data_o): exactly one result
// word per input word, in order, giving the token's kind and unpacked fields.
// Path: an accepted word passes the input register, then the decode logic with
// opcode ROM lookup and field slicing, then the result register, which drives
// out_valid_o and out_data_o.
// Throughput is one word per cycle while the output is not stalled; decode
// state advances as a word moves from the input register into the result register.
// Reset: both registers empty, decoder halted; words before a program start
// come back as ignored.
// Output stall: the result holds until taken, and one more word waits in the
// input register; in_ready_o drops only when both are full and out_ready_i
// is low.
module shader_bytecode_token_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sbtd_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sbtd_pkg::out_word_t out_data_o
);
  import sbtd_pkg::*;

  logic      stage_valid;
  in_word_t  stage_word;
  logic      out_room;
  logic      move;
  out_word_t result;

  assign move = stage_valid && out_room;

  sbtd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .take_i     (move),
    .valid_o    (stage_valid),
    .data_o     (stage_word)
  );

  sbtd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .word_i    (stage_word),
    .advance_i (move),
    .result_o  (result)
  );

  sbtd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (stage_valid),
    .data_i      (result),
    .ready_o     (out_room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/sbtd_in_stage.sv -----
module sbtd_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sbtd_pkg::in_word_t in_data_i,
  input  logic              take_i,
  output logic              valid_o,
  output sbtd_pkg::in_word_t data_o
);
  import sbtd_pkg::*;

  logic     valid_q, valid_d;
  in_word_t data_q;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/sbtd_decode.sv -----
module sbtd_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbtd_pkg::in_word_t  word_i,
  input  logic                advance_i,
  output sbtd_pkg::out_word_t result_o
);
  import sbtd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] tokens_left_q, tokens_left_d;
  logic [3:0]  pos_q, pos_d;
  class_e      cls_q, cls_d;
  logic        dst_q, dst_d;
  logic [1:0]  src_q, src_d;

  logic [31:0] tok;
  logic        start;
  logic [15:0] op_type;
  logic [15:0] comment_len;
  logic [3:0]  instr_len;
  op_info_t    info;
  logic        reject;
  logic [15:0] tl_dec;
  logic [3:0]  par_end;

  assign tok         = word_i.token;
  assign start       = word_i.program_start;
  assign op_type     = tok[15:0];
  assign comment_len = tok[31:16];
  assign instr_len   = tok[27:24];
  assign info        = op_rom_lookup(op_type);
  assign reject      = (tok[31:16] != SHADER_TYPE_PS) || (tok[15:8] < MIN_MAJOR);
  assign tl_dec      = tokens_left_q - 16'd1;
  assign par_end     = 4'(dst_q) + 4'(src_q);

  function automatic out_word_t put_dst(input out_word_t o, input logic [31:0] t);
    out_word_t r;
    r                 = o;
    r.kind            = KIND_DST;
    r.reg_number      = t[10:0];
    r.reg_type        = {t[12:11], t[30:28]};
    r.mask_or_swizzle = {4'd0, t[19:16]};
    r.modifier        = t[22:20];
    return r;
  endfunction

  function automatic out_word_t put_src(input out_word_t o, input logic [31:0] t);
    out_word_t r;
    r                 = o;
    r.kind            = KIND_SRC;
    r.reg_number      = t[10:0];
    r.reg_type        = {t[12:11], t[30:28]};
    r.mask_or_swizzle = t[23:16];
    r.modifier        = t[26:24];
    return r;
  endfunction

  // next state
  always_comb begin
    phase_d       = phase_q;
    tokens_left_d = tokens_left_q;
    pos_d         = pos_q;
    cls_d         = cls_q;
    dst_d         = dst_q;
    src_d         = src_q;
    if (start) begin
      tokens_left_d = '0;
      pos_d         = '0;
      cls_d         = CLS_GENERIC;
      dst_d         = 1'b0;
      src_d         = '0;
      phase_d       = reject ? PH_HALTED : PH_OPCODE;
    end else begin
      unique case (phase_q)
        PH_OPCODE: begin
          if (op_type == OP_END) begin
            phase_d = PH_HALTED;
          end else if (op_type == OP_COMMENT) begin
            tokens_left_d = comment_len;
            phase_d       = (comment_len != '0) ? PH_COMMENT : PH_OPCODE;
          end else begin
            dst_d         = info.dst;
            src_d         = info.src;
            cls_d         = (op_type == OP_DEF) ? CLS_DEF :
                            (op_type == OP_DCL) ? CLS_DCL : CLS_GENERIC;
            tokens_left_d = 16'(instr_len);
            pos_d         = '0;
            phase_d       = (instr_len != '0) ? PH_INSTR : PH_OPCODE;
          end
        end
        PH_COMMENT: begin
          tokens_left_d = tl_dec;
          if (tl_dec == '0) begin
            phase_d = PH_OPCODE;
          end
        end
        PH_INSTR: begin
          pos_d         = pos_q + 4'd1;
          tokens_left_d = tl_dec;
          if (tl_dec == '0) begin
            phase_d = PH_OPCODE;
          end
        end
        PH_HALTED: begin
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    result_o          = '0;
    result_o.raw_word = tok;
    result_o.kind     = KIND_IGNORED;
    if (start) begin
      result_o.kind               = reject ? KIND_REJECTED : KIND_VERSION_OK;
      result_o.type_code          = tok[31:16];
      result_o.major_or_dst_count = tok[15:8];
      result_o.minor_or_src_count = tok[7:0];
    end else begin
      unique case (phase_q)
        PH_OPCODE: begin
          result_o.type_code = op_type;
          if (op_type == OP_END) begin
            result_o.kind = KIND_END;
          end else if (op_type == OP_COMMENT) begin
            result_o.kind         = KIND_COMMENT_HEAD;
            result_o.length_count = comment_len;
          end else begin
            result_o.kind               = KIND_OPCODE;
            result_o.major_or_dst_count = 8'(info.dst);
            result_o.minor_or_src_count = 8'(info.src);
            result_o.length_count       = 16'(instr_len);
          end
        end
        PH_COMMENT: begin
          result_o.kind         = KIND_COMMENT_BODY;
          result_o.length_count = tl_dec;
        end
        PH_INSTR: begin
          case (cls_q)
            CLS_DEF: begin
              if (pos_q == '0) begin
                result_o = put_dst(result_o, tok);
              end else begin
                result_o.kind = (pos_q <= 4'd4) ? KIND_DEF_VALUE : KIND_EXTRA;
              end
            end
            CLS_DCL: begin
              if (pos_q == 4'd0) begin
                result_o.kind        = KIND_DCL_USAGE;
                result_o.usage       = tok[3:0];
                result_o.usage_index = tok[19:16];
              end else if (pos_q == 4'd1) begin
                result_o = put_dst(result_o, tok);
              end else begin
                result_o.kind = KIND_EXTRA;
              end
            end
            default: begin
              if (pos_q < 4'(dst_q)) begin
                result_o = put_dst(result_o, tok);
              end else if (pos_q < par_end) begin
                result_o = put_src(result_o, tok);
              end else begin
                result_o.kind = KIND_EXTRA;
              end
            end
          endcase
        end
        PH_HALTED: begin
          result_o.kind = KIND_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HALTED;
      tokens_left_q <= '0;
      pos_q         <= '0;
      cls_q         <= CLS_GENERIC;
      dst_q         <= 1'b0;
      src_q         <= '0;
    end else if (advance_i) begin
      phase_q       <= phase_d;
      tokens_left_q <= tokens_left_d;
      pos_q         <= pos_d;
      cls_q         <= cls_d;
      dst_q         <= dst_d;
      src_q         <= src_d;
    end
  end

endmodule

// ----- rtl/sbtd_out_stage.sv -----
module sbtd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  sbtd_pkg::out_word_t data_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sbtd_pkg::out_word_t out_data_o
);
  import sbtd_pkg::*;

  logic      valid_q, valid_d;
  out_word_t data_q;

  assign ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- rtl/sbtd_checker.sv -----
`include "shader_bytecode_token_decoder_defines.svh"

module sbtd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input sbtd_pkg::out_word_t out_data_o
);
  import sbtd_pkg::*;

  `SBTD_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_data_o), "stalled result word changed")

  `SBTD_ASSERT_IMP(a_out_origin, $rose(out_valid_o),
                   $past(in_valid_i && in_ready_o, 2), "result word without input word")

  `SBTD_ASSERT_IMP(a_empty_ready, !out_valid_o, in_ready_o,
                   "input stalled while result register empty")

  `SBTD_ASSERT_IMP(a_param_fields,
                   out_valid_o && (out_data_o.kind == KIND_DST || out_data_o.kind == KIND_SRC),
                   out_data_o.reg_number == out_data_o.raw_word[10:0] &&
                   out_data_o.reg_type == {out_data_o.raw_word[12:11], out_data_o.raw_word[30:28]},
                   "register fields do not match token")

  `SBTD_ASSERT_IMP(a_version_ok, out_valid_o && out_data_o.kind == KIND_VERSION_OK,
                   out_data_o.type_code == SHADER_TYPE_PS &&
                   out_data_o.major_or_dst_count >= MIN_MAJOR,
                   "accepted version is not a valid pixel shader")

endmodule

bind shader_bytecode_token_decoder sbtd_checker u_sbtd_checker (.*);

// ----- dv/testbench.sv -----
module testbench;
  import sbtd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  class decoded_word_tracker;
    phase_e      cur_phase;
    logic [15:0] tokens_left;
    logic [3:0]  slot;
    class_e      cls;
    logic        has_dst;
    logic [1:0]  n_src;
    out_word_t   pending_results[$];
    int          mismatches;

    function new();
      cur_phase   = PH_HALTED;
      tokens_left = '0;
      slot        = '0;
      cls         = CLS_GENERIC;
      has_dst     = 1'b0;
      n_src       = '0;
      mismatches  = 0;
    endfunction

    // {dst, src[1:0]} parameter counts; types past the table take its last entry
    function logic [2:0] op_params(logic [15:0] op);
      int unsigned i;
      i = (op < OPCODE_TABLE_DEPTH) ? op : OPCODE_TABLE_DEPTH - 1;
      case (i)
        1, 6, 7, 14, 15, 16, 19, 35, 36:               return 3'b101;
        2, 3, 5, 8, 9, 10, 11, 12, 13, 17, 32, 66:     return 3'b110;
        4, 18, 37, 80, 88, 90:                         return 3'b111;
        default:                                       return 3'b000;
      endcase
    endfunction

    function out_word_t dst_fields(logic [31:0] t);
      out_word_t r;
      r                 = '0;
      r.kind            = KIND_DST;
      r.reg_number      = t[10:0];
      r.reg_type        = {t[12:11], t[30:28]};
      r.mask_or_swizzle = {4'd0, t[19:16]};
      r.modifier        = t[22:20];
      r.raw_word        = t;
      return r;
    endfunction

    function out_word_t src_fields(logic [31:0] t);
      out_word_t r;
      r                 = '0;
      r.kind            = KIND_SRC;
      r.reg_number      = t[10:0];
      r.reg_type        = {t[12:11], t[30:28]};
      r.mask_or_swizzle = t[23:16];
      r.modifier        = t[26:24];
      r.raw_word        = t;
      return r;
    endfunction

    function out_word_t decode_token(in_word_t w);
      out_word_t   r;
      logic [31:0] t;
      logic [15:0] op;
      logic [2:0]  cnt;
      t          = w.token;
      r          = '0;
      r.kind     = KIND_IGNORED;
      r.raw_word = t;
      if (w.program_start) begin
        r.type_code          = t[31:16];
        r.major_or_dst_count = t[15:8];
        r.minor_or_src_count = t[7:0];
        tokens_left = '0;
        slot        = '0;
        cls         = CLS_GENERIC;
        has_dst     = 1'b0;
        n_src       = '0;
        if (t[31:16] != SHADER_TYPE_PS || t[15:8] < MIN_MAJOR) begin
          r.kind    = KIND_REJECTED;
          cur_phase = PH_HALTED;
        end else begin
          r.kind    = KIND_VERSION_OK;
          cur_phase = PH_OPCODE;
        end
        return r;
      end
      case (cur_phase)
        PH_OPCODE: begin
          op          = t[15:0];
          r.type_code = op;
          if (op == OP_END) begin
            r.kind    = KIND_END;
            cur_phase = PH_HALTED;
          end else if (op == OP_COMMENT) begin
            r.kind         = KIND_COMMENT_HEAD;
            r.length_count = t[31:16];
            tokens_left    = t[31:16];
            cur_phase      = (t[31:16] != 16'd0) ? PH_COMMENT : PH_OPCODE;
          end else begin
            cnt     = op_params(op);
            has_dst = cnt[2];
            n_src   = cnt[1:0];
            cls     = (op == OP_DEF) ? CLS_DEF : ((op == OP_DCL) ? CLS_DCL : CLS_GENERIC);
            r.kind               = KIND_OPCODE;
            r.major_or_dst_count = {7'd0, has_dst};
            r.minor_or_src_count = {6'd0, n_src};
            r.length_count       = {12'd0, t[27:24]};
            tokens_left          = {12'd0, t[27:24]};
            slot                 = '0;
            cur_phase            = (t[27:24] != 4'd0) ? PH_INSTR : PH_OPCODE;
          end
        end
        PH_COMMENT: begin
          tokens_left    = tokens_left - 16'd1;
          r.kind         = KIND_COMMENT_BODY;
          r.length_count = tokens_left;
          if (tokens_left == 16'd0) cur_phase = PH_OPCODE;
        end
        PH_INSTR: begin
          case (cls)
            CLS_DEF: begin
              if (slot == 4'd0) r = dst_fields(t);
              else r.kind = (slot <= 4'd4) ? KIND_DEF_VALUE : KIND_EXTRA;
            end
            CLS_DCL: begin
              if (slot == 4'd0) begin
                r.kind        = KIND_DCL_USAGE;
                r.usage       = t[3:0];
                r.usage_index = t[19:16];
              end else if (slot == 4'd1) begin
                r = dst_fields(t);
              end else begin
                r.kind = KIND_EXTRA;
              end
            end
            default: begin
              if (slot < 4'(has_dst)) r = dst_fields(t);
              else if (slot < 4'(has_dst) + 4'(n_src)) r = src_fields(t);
              else r.kind = KIND_EXTRA;
            end
          endcase
          slot        = slot + 4'd1;
          tokens_left = tokens_left - 16'd1;
          if (tokens_left == 16'd0) cur_phase = PH_OPCODE;
        end
        default: begin
          r.kind = KIND_IGNORED;
        end
      endcase
      return r;
    endfunction

    function void note_input(in_word_t w);
      pending_results.push_back(decode_token(w));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report(string what, logic [31:0] token, logic [31:0] got, logic [31:0] want);
      if (mismatches < 50)
        $display("MISMATCH %s: token %h got %0h expected %0h", what, token, got, want);
      mismatches++;
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (pending_results.size() == 0) begin
        report("word with no expectation", got.raw_word, got.kind, 0);
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind)
        report("kind", want.raw_word, got.kind, want.kind);
      if (got.type_code !== want.type_code)
        report("type_code", want.raw_word, got.type_code, want.type_code);
      if (got.major_or_dst_count !== want.major_or_dst_count)
        report("major_or_dst_count", want.raw_word, got.major_or_dst_count,
               want.major_or_dst_count);
      if (got.minor_or_src_count !== want.minor_or_src_count)
        report("minor_or_src_count", want.raw_word, got.minor_or_src_count,
               want.minor_or_src_count);
      if (got.length_count !== want.length_count)
        report("length_count", want.raw_word, got.length_count, want.length_count);
      if (got.reg_number !== want.reg_number)
        report("reg_number", want.raw_word, got.reg_number, want.reg_number);
      if (got.reg_type !== want.reg_type)
        report("reg_type", want.raw_word, got.reg_type, want.reg_type);
      if (got.mask_or_swizzle !== want.mask_or_swizzle)
        report("mask_or_swizzle", want.raw_word, got.mask_or_swizzle, want.mask_or_swizzle);
      if (got.modifier !== want.modifier)
        report("modifier", want.raw_word, got.modifier, want.modifier);
      if (got.usage !== want.usage)
        report("usage", want.raw_word, got.usage, want.usage);
      if (got.usage_index !== want.usage_index)
        report("usage_index", want.raw_word, got.usage_index, want.usage_index);
      if (got.raw_word !== want.raw_word)
        report("raw_word", want.raw_word, got.raw_word, want.raw_word);
    endtask
  endclass

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;

  decoded_word_tracker model;
  in_word_t            token_q[$];
  int                  results_seen = 0;
  int                  cycles       = 0;
  bit                  src_burst    = 1'b0;

  shader_bytecode_token_decoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push(logic [31:0] t, logic s);
    token_q.push_back('{token: t, program_start: s});
  endtask

  // one program: version, a few instructions, usually an END
  task automatic gen_program();
    int          n_instr;
    int          r;
    logic [15:0] op;
    logic [15:0] clen;
    logic [3:0]  len;
    logic [2:0]  cnt;
    if ($urandom_range(0, 9) == 0) begin
      push($urandom, 1'b1);
      repeat ($urandom_range(0, 2)) push($urandom, 1'b0);
      return;
    end
    push({16'hffff, 8'($urandom_range(2, 255)), 8'($urandom)}, 1'b1);
    n_instr = $urandom_range(1, 8);
    for (int i = 0; i < n_instr; i++) begin
      r = $urandom_range(0, 99);
      if (r >= 92) begin
        push($urandom, 1'($urandom_range(0, 1)));
        continue;
      end
      if (r >= 65 && r < 78) begin
        if ($urandom_range(0, 9) == 0) begin
          // long comment cut short by the next program
          push({16'($urandom), OP_COMMENT}, 1'b0);
          repeat ($urandom_range(0, 5)) push($urandom, 1'b0);
          return;
        end
        clen = 16'($urandom_range(0, 4));
        push({clen, OP_COMMENT}, 1'b0);
        repeat (clen) push($urandom, 1'b0);
        continue;
      end
      if (r < 40) op = 16'($urandom_range(1, 19));
      else if (r < 48) op = 16'($urandom_range(0, 97));
      else if (r < 55) op = OP_DEF;
      else if (r < 65) op = OP_DCL;
      else op = 16'($urandom);
      cnt = model.op_params(op);
      if (op == OP_DEF) len = 4'd5;
      else if (op == OP_DCL) len = 4'd2;
      else len = 4'(cnt[2]) + 4'(cnt[1:0]);
      if ($urandom_range(0, 6) == 0) len = 4'($urandom_range(0, 15));
      push({4'($urandom), len, 8'($urandom), op}, 1'b0);
      repeat (len) push($urandom, 1'b0);
    end
    if ($urandom_range(0, 99) < 85) begin
      push({16'($urandom), OP_END}, 1'b0);
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) push($urandom, 1'b0);
    end
  endtask

  task automatic send_word(input in_word_t w);
    int gap;
    if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
    gap = (src_burst || $urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    model.note_input(w);
  endtask

  initial begin : result_sink
    int stall;
    bit burst;
    bit pressure_done;
    burst         = 1'b0;
    pressure_done = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) burst = !burst;
      if (!pressure_done && results_seen >= 100) begin
        // long hold-off so the block backs up into its input
        stall         = 150;
        pressure_done = 1'b1;
      end else begin
        stall = (burst || $urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      model.check_result(out_data_o);
      results_seen++;
    end
  end

  initial begin
    model = new();

    push(32'h1234_5678, 1'b0);             // halted, no start
    push(32'hfffe_0300, 1'b1);             // wrong shader type
    push(32'hffff_01ff, 1'b1);             // major too low
    push(32'hffff_0200, 1'b1);
    push({16'h0000, OP_COMMENT}, 1'b0);    // empty comment
    push({16'h0001, OP_COMMENT}, 1'b0);
    push(32'hffff_ffff, 1'b0);
    push({8'hf6, 8'hff, OP_DEF}, 1'b0);    // DEF with one extra word
    push(32'hffff_ffff, 1'b0);
    push(32'h0000_0000, 1'b0);
    push(32'h0000_0001, 1'b0);
    push(32'h8000_0000, 1'b0);
    push(32'h7fff_ffff, 1'b0);
    push(32'hdead_beef, 1'b0);
    push({8'h02, 8'h00, OP_DCL}, 1'b0);
    push(32'h000f_000f, 1'b0);
    push(32'h8000_0800, 1'b0);
    push(32'h0200_0004, 1'b0);             // mad cut short
    push(32'h0000_0000, 1'b0);
    push(32'hffff_ffff, 1'b0);
    push(32'h0100_fffd, 1'b0);             // past the opcode table
    push(32'h5555_aaaa, 1'b0);
    push(32'h0000_0000, 1'b0);             // zero length
    push({8'h02, 8'h00, OP_DCL}, 1'b0);
    push(32'hffff_ff7f, 1'b1);             // restart mid instruction
    push({16'h0000, OP_END}, 1'b0);
    push(32'hffff_ffff, 1'b0);
    while (token_q.size() < 627) gen_program();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (token_q[i]) send_word(token_q[i]);
    in_valid_i <= 1'b0;

    while (model.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (model.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
